[hw/rtl/tpocwm_pkg.sv]
`default_nettype none
package tpocwm_pkg;

	localparam logic [1:0] CMD_CAL_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_END_CAL    = 2'd1;
	localparam logic [1:0] CMD_MON_SAMPLE = 2'd2;
	localparam logic [1:0] CMD_VOLTAGE    = 2'd3;

	localparam logic [2:0] STS_OK        = 3'd0;
	localparam logic [2:0] STS_OVER_V    = 3'd1;
	localparam logic [2:0] STS_UNDER_V   = 3'd2;
	localparam logic [2:0] STS_OC_BASE   = 3'd3;
	localparam logic [2:0] STS_CAL_DONE  = 3'd6;
	localparam logic [2:0] STS_CAL_ERROR = 3'd7;

	localparam logic [1:0] REG_CURRENT_MARGIN = 2'd0;
	localparam logic [1:0] REG_VOLTAGE_LOW    = 2'd1;
	localparam logic [1:0] REG_VOLTAGE_HIGH   = 2'd2;

	localparam logic [1:0] PHASE_U = 2'd0;
	localparam logic [1:0] PHASE_W = 2'd2;

	localparam int NUM_PHASES = 3;
	localparam int RES_BITS   = 67;
	localparam int TDATA_OUT  = 72;

	// payload of one result, lowest field last
	typedef struct packed {
		logic [15:0]        window_high;
		logic [15:0]        window_low;
		logic signed [16:0] signed_current;
		logic [15:0]        raw_value;
		logic [1:0]         phase;
	} res_t;

endpackage
`default_nettype wire

[hw/rtl/three_phase_overcurrent_window_monitor.sv]
`default_nettype none
// Three-phase overcurrent and dc-link voltage window monitor.
// Input stream s_axis: tuser carries the command (calibration sample, end of
// calibration, monitored current sample, voltage sample), tdata the raw ADC
// sample. Current samples take their phase U, V, W in turn.
// Output stream m_axis: one result item per input item; tuser carries the
// status, tdata the phase, sample, signed current and the window in force.
// Configuration: cfg_wen writes cfg_wdata into register cfg_index
// (0 current margin, 1 voltage low, 2 voltage high), taken at once.
// Each item passes through an input register and then the result register;
// the next item is accepted only once the held one has moved on. End of
// calibration with samples for every phase runs a restoring divider shared
// by the three phases, one quotient bit a cycle. The input register lets
// the next item be accepted while a result waits at the output.
// Reset clears sums, counts, offsets, phase position and registers to
// their start values; the window opens fully. A stalled receiver holds the
// result register, and once the input register is also full s_axis_tready
// stays low until the result is taken.
module three_phase_overcurrent_window_monitor #(
	parameter int SAMPLE_BITS       = 16,
	parameter int MAX_CAL_PER_PHASE = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // sample
	input  wire logic [1:0]  s_axis_tuser,  // command
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// phase, raw_value, signed_current, window_low, window_high, zero fill
	output logic [tpocwm_pkg::TDATA_OUT-1:0] m_axis_tdata,
	output logic [2:0]       m_axis_tuser   // status
);
	import tpocwm_pkg::*;

	localparam int CW = $clog2(MAX_CAL_PER_PHASE + 1);
	localparam int SW = SAMPLE_BITS + CW;
	localparam int BW = $clog2(SW);
	localparam logic [15:0] FULL_SCALE = 16'((32'd1 << SAMPLE_BITS) - 32'd1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_CAL_PER_PHASE);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]    state_q;
	logic          inq_valid_q;
	logic [1:0]    cmd_q;
	logic [15:0]   smp_q;
	logic [15:0]   margin_q, vlow_q, vhigh_q;
	logic [1:0]    pos_q;
	logic [SW-1:0] sum_q [NUM_PHASES];
	logic [CW-1:0] cnt_q [NUM_PHASES];
	logic [15:0]   off_q [NUM_PHASES];
	logic [15:0]   wlo_q, whi_q;
	logic [1:0]    div_ph_q;
	logic [BW-1:0] bit_q;
	logic [SW-1:0] quo_q;
	logic [CW-1:0] rem_q;
	logic          out_valid_q;
	logic [2:0]    out_status_q;
	res_t          res_q;

	logic          out_free;
	logic          out_load;
	logic [1:0]    rd_idx;
	logic [CW-1:0] rd_cnt;
	logic [15:0]   s_m;
	logic [1:0]    pos_nxt;
	logic          cal_ok;
	logic [CW:0]   trial;
	logic [CW:0]   diff;
	logic          ge;
	logic [SW-1:0] quo_nxt;
	logic [15:0]   mn, mx;
	logic [16:0]   top;
	logic [15:0]   new_whi, new_wlo;
	logic [16:0]   cur;
	logic [2:0]    item_status;
	res_t          item_res;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !inq_valid_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {{(TDATA_OUT - RES_BITS){1'b0}}, res_q};

	assign rd_idx  = (state_q == ST_IDLE) ? pos_q : div_ph_q;
	assign rd_cnt  = cnt_q[rd_idx];
	assign s_m     = smp_q & FULL_SCALE;
	assign pos_nxt = (pos_q == PHASE_W) ? PHASE_U : pos_q + 2'd1;
	assign cal_ok  = (cnt_q[0] != '0) && (cnt_q[1] != '0) && (cnt_q[2] != '0);
	assign out_load = out_free && (state_q == ST_FIN ||
		(state_q == ST_IDLE && inq_valid_q && !(cmd_q == CMD_END_CAL && cal_ok)));

	// one step of the shared restoring divider
	assign trial   = {rem_q, quo_q[SW-1]};
	assign diff    = trial - {1'b0, rd_cnt};
	assign ge      = (trial >= {1'b0, rd_cnt});
	assign quo_nxt = {quo_q[SW-2:0], ge};

	always_comb begin
		mn = off_q[0];
		mx = off_q[0];
		for (int k = 1; k < NUM_PHASES; k++) begin
			if (off_q[k] < mn) mn = off_q[k];
			if (off_q[k] > mx) mx = off_q[k];
		end
		top     = {1'b0, mn} + {1'b0, margin_q};
		new_whi = (top > {1'b0, FULL_SCALE}) ? FULL_SCALE : top[15:0];
		new_wlo = (mx > margin_q) ? mx - margin_q : 16'd0;
	end

	always_comb begin
		cur = (pos_q == PHASE_U) ? {1'b0, off_q[pos_q]} - {1'b0, s_m}
		                         : {1'b0, s_m} - {1'b0, off_q[pos_q]};
		item_status = STS_OK;
		item_res    = '0;
		item_res.window_low  = wlo_q;
		item_res.window_high = whi_q;
		case (cmd_q)
			CMD_CAL_SAMPLE: begin
				item_res.phase     = pos_q;
				item_res.raw_value = s_m;
			end
			CMD_END_CAL: begin
				item_status = STS_CAL_ERROR;
			end
			CMD_MON_SAMPLE: begin
				item_res.phase          = pos_q;
				item_res.raw_value      = s_m;
				item_res.signed_current = cur;
				if (s_m < wlo_q || s_m > whi_q)
					item_status = STS_OC_BASE + {1'b0, pos_q};
			end
			default: begin
				item_res.raw_value   = s_m;
				item_res.window_low  = vlow_q;
				item_res.window_high = vhigh_q;
				if (s_m >= vhigh_q)
					item_status = STS_OVER_V;
				else if (s_m < vlow_q)
					item_status = STS_UNDER_V;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= 16'd0;
			vlow_q   <= 16'd0;
			vhigh_q  <= 16'hFFFF;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_CURRENT_MARGIN: margin_q <= cfg_wdata;
				REG_VOLTAGE_LOW:    vlow_q   <= cfg_wdata;
				REG_VOLTAGE_HIGH:   vhigh_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_q <= s_axis_tuser;
			smp_q <= s_axis_tdata;
		end
		if (state_q == ST_LOAD) begin
			quo_q <= sum_q[div_ph_q];
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			quo_q <= quo_nxt;
			rem_q <= ge ? diff[CW-1:0] : trial[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			inq_valid_q  <= 1'b0;
			pos_q        <= PHASE_U;
			div_ph_q     <= PHASE_U;
			bit_q        <= '0;
			wlo_q        <= 16'd0;
			whi_q        <= 16'hFFFF;
			out_valid_q  <= 1'b0;
			out_status_q <= STS_OK;
			res_q        <= '0;
			for (int k = 0; k < NUM_PHASES; k++) begin
				sum_q[k] <= '0;
				cnt_q[k] <= '0;
				off_q[k] <= 16'd0;
			end
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			if (s_axis_tvalid && s_axis_tready)
				inq_valid_q <= 1'b1;
			case (state_q)
				ST_IDLE: begin
					if (inq_valid_q) begin
						if (cmd_q == CMD_END_CAL && cal_ok) begin
							state_q  <= ST_LOAD;
							div_ph_q <= PHASE_U;
						end else if (out_free) begin
							inq_valid_q  <= 1'b0;
							out_status_q <= item_status;
							res_q        <= item_res;
							if (cmd_q == CMD_CAL_SAMPLE) begin
								pos_q <= pos_nxt;
								if (rd_cnt < CNT_MAX) begin
									sum_q[pos_q] <= sum_q[pos_q] + SW'(s_m);
									cnt_q[pos_q] <= rd_cnt + CW'(1);
								end
							end else if (cmd_q == CMD_MON_SAMPLE) begin
								pos_q <= pos_nxt;
							end else if (cmd_q == CMD_END_CAL) begin
								pos_q <= PHASE_U;
								for (int k = 0; k < NUM_PHASES; k++) begin
									sum_q[k] <= '0;
									cnt_q[k] <= '0;
								end
							end
						end
					end
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
					bit_q   <= BW'(SW - 1);
				end
				ST_DIV: begin
					if (bit_q == '0) begin
						off_q[div_ph_q] <= 16'(quo_nxt[SAMPLE_BITS-1:0]);
						if (div_ph_q == PHASE_W) begin
							state_q <= ST_FIN;
						end else begin
							div_ph_q <= div_ph_q + 2'd1;
							state_q  <= ST_LOAD;
						end
					end else begin
						bit_q <= bit_q - BW'(1);
					end
				end
				default: begin
					if (out_free) begin
						wlo_q        <= new_wlo;
						whi_q        <= new_whi;
						out_status_q <= STS_CAL_DONE;
						res_q        <= '{window_high: new_whi, window_low: new_wlo,
						                  signed_current: '0, raw_value: '0, phase: '0};
						pos_q        <= PHASE_U;
						inq_valid_q  <= 1'b0;
						state_q      <= ST_IDLE;
						for (int k = 0; k < NUM_PHASES; k++) begin
							sum_q[k] <= '0;
							cnt_q[k] <= '0;
						end
					end
				end
			endcase
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != 2'd3 && div_ph_q != 2'd3)
		else $error("phase index out of range");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rd_cnt != '0)
		else $error("divider running on a zero count");

	a_busy_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> inq_valid_q && cmd_q == CMD_END_CAL)
		else $error("division running without an end of calibration item");

	a_cal_done_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q == STS_CAL_DONE |->
			res_q.phase == 2'd0 && res_q.raw_value == 16'd0 &&
			res_q.signed_current == 17'sd0)
		else $error("calibration result carries sample fields");

	a_window_update: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE && $past(state_q) == ST_IDLE |->
			$stable(wlo_q) && $stable(whi_q))
		else $error("current window changed outside calibration end");

endmodule
`default_nettype wire

[sim/three_phase_overcurrent_window_monitor_checker.sv]
`timescale 1ns / 100ps
module three_phase_overcurrent_window_monitor_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [1:0]                       cfg_index,
	input  logic [15:0]                      cfg_wdata,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [15:0]                      s_tdata,
	input  logic [1:0]                       s_tuser,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [tpocwm_pkg::TDATA_OUT-1:0] m_tdata,
	input  logic [2:0]                       m_tuser,
	output int                               mismatches,
	output int                               outstanding,
	output int                               results_checked,
	output logic [7:0]                       statuses_seen,
	output logic [15:0]                      window_low_now,
	output logic [15:0]                      window_high_now
);
	import tpocwm_pkg::*;

	localparam int CAL_LIMIT = 4096;

	typedef struct packed {
		logic [2:0] status;
		res_t       fields;
	} judgement_t;

	logic [15:0] margin;
	logic [15:0] volt_low;
	logic [15:0] volt_high;
	logic [1:0]  next_phase;
	logic [27:0] phase_sum [NUM_PHASES];
	logic [12:0] phase_count [NUM_PHASES];
	logic [15:0] phase_offset [NUM_PHASES];
	logic [15:0] win_low;
	logic [15:0] win_high;
	judgement_t  awaited_q [$];

	assign window_low_now  = win_low;
	assign window_high_now = win_high;

	function automatic logic [1:0] claim_phase();
		logic [1:0] p;
		p = (next_phase >= NUM_PHASES) ? PHASE_U : next_phase;
		next_phase = (p == PHASE_W) ? PHASE_U : p + 2'd1;
		return p;
	endfunction

	function automatic judgement_t judge_item(logic [1:0] cmd, logic [15:0] s);
		judgement_t         j;
		logic [1:0]         p;
		logic [15:0]        lowest;
		logic [15:0]        highest;
		logic [16:0]        ceiling;
		logic signed [16:0] diff;
		bit                 all_counted;
		int                 k;
		j = '0;
		j.status = STS_OK;
		j.fields.window_low = win_low;
		j.fields.window_high = win_high;
		case (cmd)
			CMD_CAL_SAMPLE: begin
				p = claim_phase();
				j.fields.phase = p;
				j.fields.raw_value = s;
				if (phase_count[p] < CAL_LIMIT) begin
					phase_sum[p] = phase_sum[p] + 28'(s);
					phase_count[p] = phase_count[p] + 13'd1;
				end
			end
			CMD_END_CAL: begin
				all_counted = 1'b1;
				for (k = 0; k < NUM_PHASES; k++)
					if (phase_count[k] == 0)
						all_counted = 1'b0;
				if (all_counted) begin
					for (k = 0; k < NUM_PHASES; k++)
						phase_offset[k] = 16'(phase_sum[k] / phase_count[k]);
					lowest = phase_offset[0];
					highest = phase_offset[0];
					for (k = 1; k < NUM_PHASES; k++) begin
						if (phase_offset[k] < lowest)
							lowest = phase_offset[k];
						if (phase_offset[k] > highest)
							highest = phase_offset[k];
					end
					ceiling = {1'b0, lowest} + {1'b0, margin};
					win_high = ceiling[16] ? 16'hFFFF : ceiling[15:0];
					win_low = (highest > margin) ? highest - margin : 16'h0000;
					j.status = STS_CAL_DONE;
				end else begin
					j.status = STS_CAL_ERROR;
				end
				for (k = 0; k < NUM_PHASES; k++) begin
					phase_sum[k] = '0;
					phase_count[k] = '0;
				end
				next_phase = PHASE_U;
				j.fields.window_low = win_low;
				j.fields.window_high = win_high;
			end
			CMD_MON_SAMPLE: begin
				p = claim_phase();
				j.fields.phase = p;
				j.fields.raw_value = s;
				diff = $signed({1'b0, s}) - $signed({1'b0, phase_offset[p]});
				if (p == PHASE_U)
					diff = -diff;
				j.fields.signed_current = diff;
				if (s < win_low || s > win_high)
					j.status = STS_OC_BASE + 3'(p);
			end
			default: begin
				j.fields.raw_value = s;
				j.fields.window_low = volt_low;
				j.fields.window_high = volt_high;
				if (s >= volt_high)
					j.status = STS_OVER_V;
				else if (s < volt_low)
					j.status = STS_UNDER_V;
			end
		endcase
		return j;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		if (mismatches <= 50)
			$display("%0t ns result %0d: %s is %0d, expected %0d",
				$time, results_checked, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		judgement_t want;
		res_t       got;
		int         k;
		if (!arst_n) begin
			margin = '0;
			volt_low = '0;
			volt_high = 16'hFFFF;
			next_phase = PHASE_U;
			for (k = 0; k < NUM_PHASES; k++) begin
				phase_sum[k] = '0;
				phase_count[k] = '0;
				phase_offset[k] = '0;
			end
			win_low = '0;
			win_high = 16'hFFFF;
			awaited_q.delete();
			mismatches = 0;
			outstanding = 0;
			results_checked = 0;
			statuses_seen = '0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_CURRENT_MARGIN: margin = cfg_wdata;
					REG_VOLTAGE_LOW:    volt_low = cfg_wdata;
					REG_VOLTAGE_HIGH:   volt_high = cfg_wdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				awaited_q.push_back(judge_item(s_tuser, s_tdata));
			if (m_tvalid && m_tready) begin
				got = res_t'(m_tdata[RES_BITS-1:0]);
				statuses_seen[m_tuser] = 1'b1;
				if (awaited_q.size() == 0) begin
					report_mismatch("item with nothing awaited, status", m_tuser, -1);
				end else begin
					want = awaited_q.pop_front();
					if (m_tuser != want.status)
						report_mismatch("status", m_tuser, want.status);
					if (got.phase != want.fields.phase)
						report_mismatch("phase", got.phase, want.fields.phase);
					if (got.raw_value != want.fields.raw_value)
						report_mismatch("raw_value", got.raw_value, want.fields.raw_value);
					if (got.signed_current != want.fields.signed_current)
						report_mismatch("signed_current", int'(got.signed_current),
							int'(want.fields.signed_current));
					if (got.window_low != want.fields.window_low)
						report_mismatch("window_low", got.window_low,
							want.fields.window_low);
					if (got.window_high != want.fields.window_high)
						report_mismatch("window_high", got.window_high,
							want.fields.window_high);
					if (m_tdata[TDATA_OUT-1:RES_BITS] != '0)
						report_mismatch("zero fill", int'(m_tdata[TDATA_OUT-1:RES_BITS]), 0);
				end
				results_checked++;
			end
			outstanding = awaited_q.size();
		end
	end

endmodule

[sim/three_phase_overcurrent_window_monitor_test.sv]
`timescale 1ns / 100ps
module three_phase_overcurrent_window_monitor_test;
	import tpocwm_pkg::*;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int RANDOM_ITEMS = 1150;
	localparam int LONG_CAL     = 40;
	localparam int IDLE_LIMIT   = 4000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 100;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wen;
	logic [1:0]           cfg_index;
	logic [15:0]          cfg_wdata;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [15:0]          s_axis_tdata;
	logic [1:0]           s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [TDATA_OUT-1:0] m_axis_tdata;
	logic [2:0]           m_axis_tuser;

	int          mismatches;
	int          outstanding;
	int          results_checked;
	logic [7:0]  statuses_seen;
	logic [15:0] cur_win_low;
	logic [15:0] cur_win_high;

	int          sender_gap_max;
	int          receiver_gap_max;
	bit          hold_request;
	int          items_sent;
	int          calibrations;
	int          reconfigs;
	logic [15:0] volt_low_set;
	logic [15:0] volt_high_set;

	three_phase_overcurrent_window_monitor dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	three_phase_overcurrent_window_monitor_checker scoreboard (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wen         (cfg_wen),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.s_tvalid        (s_axis_tvalid),
		.s_tready        (s_axis_tready),
		.s_tdata         (s_axis_tdata),
		.s_tuser         (s_axis_tuser),
		.m_tvalid        (m_axis_tvalid),
		.m_tready        (m_axis_tready),
		.m_tdata         (m_axis_tdata),
		.m_tuser         (m_axis_tuser),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.statuses_seen   (statuses_seen),
		.window_low_now  (cur_win_low),
		.window_high_now (cur_win_high)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = hold_request ? HOLD_CYCLES : $urandom_range(0, receiver_gap_max);
			hold_request = 1'b0;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("watchdog: %0d cycles without a handshake", IDLE_LIMIT);
		$display("three_phase_overcurrent_window_monitor verification failed");
		$finish;
	end

	task automatic push_item(logic [1:0] cmd, logic [15:0] sample);
		int gap;
		gap = $urandom_range(0, sender_gap_max);
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= sample;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (outstanding == 0);
	endtask

	task automatic set_limits(logic [15:0] margin, logic [15:0] vlow, logic [15:0] vhigh,
			bit spare);
		@(negedge clk);
		cfg_wen <= 1'b1;
		if (spare) begin
			cfg_index <= REG_SPARE;
			cfg_wdata <= 16'($urandom);
			@(negedge clk);
		end
		cfg_index <= REG_CURRENT_MARGIN;
		cfg_wdata <= margin;
		@(negedge clk);
		cfg_index <= REG_VOLTAGE_LOW;
		cfg_wdata <= vlow;
		@(negedge clk);
		cfg_index <= REG_VOLTAGE_HIGH;
		cfg_wdata <= vhigh;
		@(negedge clk);
		cfg_wen <= 1'b0;
		volt_low_set = vlow;
		volt_high_set = vhigh;
		reconfigs++;
	endtask

	function automatic logic [15:0] pick_current();
		case ($urandom_range(0, 6))
			0: return cur_win_low - 16'd1;
			1: return cur_win_low;
			2: return cur_win_high;
			3: return cur_win_high + 16'd1;
			4: return 16'($urandom);
			default: return 16'((int'(cur_win_low) + int'(cur_win_high)) / 2
				+ $urandom_range(0, 64) - 32);
		endcase
	endfunction

	function automatic logic [15:0] pick_voltage();
		case ($urandom_range(0, 5))
			0: return volt_low_set - 16'd1;
			1: return volt_low_set;
			2: return volt_high_set - 16'd1;
			3: return volt_high_set;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic run_calibrated_episode();
		int          rounds;
		int          watch;
		int          i;
		logic [15:0] base;
		rounds = $urandom_range(1, 6);
		if ($urandom_range(0, 3) == 0)
			base = 16'($urandom);
		else
			base = 16'(32768 + $urandom_range(0, 2000) - 1000);
		for (i = 0; i < rounds * 3; i++) begin
			if ($urandom_range(0, 9) == 0)
				push_item(CMD_CAL_SAMPLE, 16'($urandom));
			else
				push_item(CMD_CAL_SAMPLE, base + 16'($urandom_range(0, 255)));
			if ($urandom_range(0, 5) == 0)
				push_item(CMD_VOLTAGE, pick_voltage());
		end
		push_item(CMD_END_CAL, 16'($urandom));
		calibrations++;
		watch = $urandom_range(4, 20);
		for (i = 0; i < watch * 3; i++) begin
			push_item(CMD_MON_SAMPLE, pick_current());
			if ($urandom_range(0, 3) == 0)
				push_item(CMD_VOLTAGE, pick_voltage());
		end
	endtask

	initial begin
		int          i;
		int          n;
		int          first_random;
		logic [15:0] m;
		logic [15:0] vl;
		logic [15:0] vh;

		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = REG_CURRENT_MARGIN;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = CMD_CAL_SAMPLE;
		hold_request = 1'b0;
		sender_gap_max = 13;
		receiver_gap_max = 13;
		items_sent = 0;
		calibrations = 0;
		reconfigs = 0;
		volt_low_set = '0;
		volt_high_set = 16'hFFFF;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// end of calibration with nothing collected
		push_item(CMD_END_CAL, 16'hFFFF);
		push_item(CMD_MON_SAMPLE, 16'h0000);
		push_item(CMD_MON_SAMPLE, 16'hFFFF);
		push_item(CMD_MON_SAMPLE, 16'h8000);
		push_item(CMD_VOLTAGE, 16'hFFFF);
		push_item(CMD_VOLTAGE, 16'h0000);
		// phase w missing
		push_item(CMD_CAL_SAMPLE, 16'h0000);
		push_item(CMD_CAL_SAMPLE, 16'hFFFF);
		push_item(CMD_END_CAL, 16'h0000);
		// offsets at the extremes give an inverted window
		push_item(CMD_CAL_SAMPLE, 16'h0000);
		push_item(CMD_CAL_SAMPLE, 16'hFFFF);
		push_item(CMD_VOLTAGE, 16'h1234);
		push_item(CMD_CAL_SAMPLE, 16'h8000);
		push_item(CMD_END_CAL, 16'h5555);
		calibrations++;
		push_item(CMD_MON_SAMPLE, 16'h0000);
		push_item(CMD_MON_SAMPLE, 16'hFFFF);
		push_item(CMD_MON_SAMPLE, 16'h7FFF);
		push_item(CMD_MON_SAMPLE, 16'hFFFF);
		push_item(CMD_MON_SAMPLE, 16'h0000);
		drain_results();
		// inverted voltage limits, saturating window
		set_limits(16'hFFFF, 16'hFFFF, 16'h0000, 1'b1);
		push_item(CMD_VOLTAGE, 16'h0000);
		push_item(CMD_VOLTAGE, 16'hFFFF);
		push_item(CMD_CAL_SAMPLE, 16'h0001);
		push_item(CMD_CAL_SAMPLE, 16'h0002);
		push_item(CMD_CAL_SAMPLE, 16'h0003);
		push_item(CMD_END_CAL, 16'h0000);
		calibrations++;

		// back pressure: receiver holds off while items keep coming
		drain_results();
		set_limits(16'd200, 16'd1000, 16'd60000, 1'b0);
		hold_request = 1'b1;
		sender_gap_max = 0;
		for (i = 0; i < 24; i++)
			push_item(CMD_MON_SAMPLE, pick_current());
		drain_results();

		// long calibration with full scale sums, receiver always ready
		receiver_gap_max = 0;
		for (i = 0; i < NUM_PHASES * LONG_CAL; i++)
			push_item(CMD_CAL_SAMPLE, 16'hFFFF);
		for (i = 0; i < NUM_PHASES * 8; i++)
			push_item(CMD_CAL_SAMPLE, 16'h0000);
		push_item(CMD_END_CAL, 16'h0000);
		calibrations++;
		for (i = 0; i < 6; i++)
			push_item(CMD_MON_SAMPLE, 16'($urandom));
		sender_gap_max = 13;
		receiver_gap_max = 13;

		first_random = items_sent;
		while (items_sent < first_random + RANDOM_ITEMS) begin
			case ($urandom_range(0, 11))
				6: begin
					for (i = 0; i < 8; i++)
						push_item(2'($urandom), 16'($urandom));
				end
				7: begin
					n = $urandom_range(0, 2);
					for (i = 0; i < n; i++)
						push_item(CMD_CAL_SAMPLE, 16'($urandom));
					push_item(CMD_END_CAL, 16'($urandom));
				end
				8, 9: begin
					drain_results();
					case ($urandom_range(0, 4))
						0: m = 16'h0000;
						1: m = 16'hFFFF;
						2: m = 16'($urandom);
						default: m = 16'($urandom_range(0, 800));
					endcase
					case ($urandom_range(0, 3))
						0: vl = 16'h0000;
						1: vl = 16'($urandom);
						default: vl = 16'($urandom_range(0, 30000));
					endcase
					case ($urandom_range(0, 4))
						0: vh = 16'hFFFF;
						1: vh = 16'h0000;
						2: vh = 16'($urandom);
						default: vh = 16'($urandom_range(30000, 65535));
					endcase
					set_limits(m, vl, vh, $urandom_range(0, 5) == 0);
					case ($urandom_range(0, 2))
						0: sender_gap_max = 0;
						1: sender_gap_max = 3;
						default: sender_gap_max = 13;
					endcase
					case ($urandom_range(0, 2))
						0: receiver_gap_max = 0;
						1: receiver_gap_max = 3;
						default: receiver_gap_max = 13;
					endcase
				end
				10: begin
					for (i = 0; i < 10; i++)
						push_item(CMD_VOLTAGE, pick_voltage());
				end
				11: begin
					n = sender_gap_max;
					hold_request = 1'b1;
					sender_gap_max = 0;
					for (i = 0; i < 24; i++)
						push_item(CMD_MON_SAMPLE, pick_current());
					sender_gap_max = n;
					drain_results();
				end
				default: run_calibrated_episode();
			endcase
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("run covered %0d items and %0d checked results over %0d calibrations",
			items_sent, results_checked, calibrations);
		$display("%0d register settings, status codes returned %b, long receiver stalls",
			reconfigs, statuses_seen);
		if (mismatches == 0)
			$display("three_phase_overcurrent_window_monitor verification clean");
		else
			$display("three_phase_overcurrent_window_monitor verification failed");
		$finish;
	end

endmodule

[three_phase_overcurrent_window_monitor.f]
hw/rtl/tpocwm_pkg.sv
hw/rtl/three_phase_overcurrent_window_monitor.sv
sim/three_phase_overcurrent_window_monitor_checker.sv
sim/three_phase_overcurrent_window_monitor_test.sv
